// File: rtl/core/ugal_pkg.sv
// ----------------------------------------------------------------------------
// ugal_pkg: shared types and constants of the glyph atlas lookup
// Payload structs, register indexes, request and result codes, and the
// control groups passed between the core, the table search and the divider.
// ----------------------------------------------------------------------------
package ugal_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int GLYPH_LIMIT = 24;

	localparam int COUNT_W  = 9;
	localparam int CWIDTH_W = 7;
	localparam int CHEIGHT_W = 7;
	localparam int COLS_W   = 9;
	localparam int GLYPH_W  = 5;
	localparam int CP_W     = 21;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd3;

	// request and result codes
	localparam logic REQ_TABLE_WRITE = 1'b0;
	localparam logic REQ_TEXT_BYTE   = 1'b1;
	localparam logic KIND_GLYPH      = 1'b0;
	localparam logic KIND_END        = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  text_byte;
		logic [7:0]  entry_index;
		logic [15:0] entry_codepoint;
	} ugal_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  cell_index;
		logic [13:0] source_x;
		logic [13:0] source_y;
		logic [10:0] pen_x;
		logic [4:0]  glyph_total;
		logic [10:0] text_width;
	} ugal_out_t;

	typedef struct packed {
		logic                en;
		logic [TABLE_AW-1:0] index;
		logic [15:0]         codepoint;
	} ugal_tbl_wr_t;

	typedef struct packed {
		logic               start;
		logic [15:0]        codepoint;
		logic [COUNT_W-1:0] count;
	} ugal_search_req_t;

	typedef struct packed {
		logic                done;
		logic                hit;
		logic [TABLE_AW-1:0] index;
	} ugal_search_rsp_t;

	typedef struct packed {
		logic              start;
		logic [7:0]        dividend;
		logic [COLS_W-1:0] divisor;
	} ugal_div_req_t;

	typedef struct packed {
		logic              done;
		logic [7:0]        quotient;
		logic [COLS_W-1:0] remainder;
	} ugal_div_rsp_t;

endpackage

// File: rtl/core/ugal_search.sv
// ----------------------------------------------------------------------------
// ugal_search: codepoint table and binary search
// Holds the sorted codepoint table in a synchronous memory and runs one
// probe per cycle: the next midpoint is formed from the returning read data.
// ----------------------------------------------------------------------------
module ugal_search (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ugal_pkg::ugal_tbl_wr_t    wr,
	input  ugal_pkg::ugal_search_req_t req,
	output ugal_pkg::ugal_search_rsp_t rsp
);
	import ugal_pkg::*;

	logic [15:0]         cp_mem [TABLE_DEPTH];
	logic [15:0]         rd_q;
	logic [TABLE_AW-1:0] rd_addr;

	logic                busy_q;
	logic                done_q;
	logic                hit_q;
	logic [TABLE_AW-1:0] idx_q;
	logic [TABLE_AW-1:0] mid_q;
	logic [COUNT_W-1:0]  lo_q;
	logic [COUNT_W-1:0]  hi_q;
	logic [15:0]         cp_q;

	logic                lt;
	logic                eq;
	logic [COUNT_W-1:0]  lo_n;
	logic [COUNT_W-1:0]  hi_n;
	logic                more;
	logic [COUNT_W:0]    sum;
	logic [TABLE_AW-1:0] mid_n;
	logic [COUNT_W-1:0]  cnt_m1;
	logic [TABLE_AW-1:0] mid0;

	always_comb begin
		lt     = rd_q < cp_q;
		eq     = rd_q == cp_q;
		// hi is exclusive so the bounds never go negative
		lo_n   = lt ? (COUNT_W'(mid_q) + COUNT_W'(1)) : lo_q;
		hi_n   = lt ? hi_q : COUNT_W'(mid_q);
		more   = lo_n < hi_n;
		sum    = {1'b0, lo_n} + {1'b0, hi_n} - (COUNT_W+1)'(1);
		mid_n  = sum[TABLE_AW:1];
		cnt_m1 = req.count - COUNT_W'(1);
		mid0   = cnt_m1[TABLE_AW:1];
		rd_addr = busy_q ? mid_n : mid0;
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			cp_mem[wr.index] <= wr.codepoint;
		end
		rd_q <= cp_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= (req.start && req.count == '0) ||
				(!req.start && busy_q && (eq || !more));
			if (req.start) begin
				if (req.count == '0) begin
					hit_q  <= 1'b0;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (eq) begin
					busy_q <= 1'b0;
					hit_q  <= 1'b1;
				end else if (!more) begin
					busy_q <= 1'b0;
					hit_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			lo_q  <= '0;
			hi_q  <= req.count;
			cp_q  <= req.codepoint;
			mid_q <= mid0;
		end else if (busy_q) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
			if (eq) begin
				idx_q <= mid_q;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.hit   = hit_q;
	assign rsp.index = idx_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("search started while busy");
	a_bounds_open: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> lo_q < hi_q)
		else $error("search running on an empty range");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (eq || !more) |=> done_q && !busy_q)
		else $error("search did not finish on a hit or empty range");

endmodule

// File: rtl/core/ugal_divmod.sv
// ----------------------------------------------------------------------------
// ugal_divmod: cell index divider
// Restoring division of the 8-bit cell index by the column count, two
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module ugal_divmod (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ugal_pkg::ugal_div_req_t req,
	output ugal_pkg::ugal_div_rsp_t rsp
);
	import ugal_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [1:0]        step_q;
	logic [7:0]        num_q;
	logic [7:0]        quo_q;
	logic [COLS_W-1:0] rem_q;
	logic [COLS_W-1:0] den_q;

	logic [COLS_W:0]   t1;
	logic [COLS_W:0]   t2;
	logic              ge1;
	logic              ge2;
	logic [COLS_W-1:0] r1;
	logic [COLS_W-1:0] r2;

	always_comb begin
		t1  = {rem_q, num_q[7]};
		ge1 = t1 >= {1'b0, den_q};
		r1  = ge1 ? COLS_W'(t1 - {1'b0, den_q}) : COLS_W'(t1);
		t2  = {r1, num_q[6]};
		ge2 = t2 >= {1'b0, den_q};
		r2  = ge2 ? COLS_W'(t2 - {1'b0, den_q}) : COLS_W'(t2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && step_q == 2'd3;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[5:0], 2'b00};
			rem_q <= r2;
			quo_q <= {quo_q[5:0], ge1, ge2};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divide started while busy");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < den_q)
		else $error("remainder not below divisor");
	a_four_steps: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> ##3 busy_q ##1 done_q)
		else $error("divide did not take four steps");

endmodule

// File: rtl/core/utf8_glyph_atlas_lookup_core.sv
// ----------------------------------------------------------------------------
// utf8_glyph_atlas_lookup_core: UTF-8 decoder with glyph atlas lookup
// Decodes a byte stream, finds each codepoint in a sorted codepoint table
// and gives the atlas cell, its pixel origin, the pen offset, and a summary
// at the end of each string.
//
// Usage: beats enter on in_valid/in_stall. A table-write beat stores one
// codepoint at entry_index; a text beat delivers one byte of the string.
// Results leave on out_valid/out_stall, at most one per input beat, in order.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Flow: a table write or a byte that completes no character leaves the core idle.
// A string end waits in its final state until the output register is free.
// A looked-up character runs the binary search, one memory read per probe and
// at most 9 probes for 256 entries; a miss gives no result. A hit then runs
// the column divider, and its done moves on to the multiply into the output
// register, which waits until the output register is free.
// Reset clears the decoder, the glyph count and the output valid and
// loads the default registers; the table holds garbage until written.
// A stalled output holds its beat; new input is taken meanwhile, and a
// following result waits in its final state until the register frees up.
// ----------------------------------------------------------------------------
module utf8_glyph_atlas_lookup_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  ugal_pkg::ugal_in_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ugal_pkg::ugal_out_t          out_data,
	input  logic                         cfg_we,
	input  logic [ugal_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ugal_pkg::CFG_W-1:0]   cfg_data
);
	import ugal_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_MUL    = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_FIN    = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	logic [2:0]           state_q;
	logic [COUNT_W-1:0]   entry_count_q;
	logic [CWIDTH_W-1:0]  cell_width_q;
	logic [CHEIGHT_W-1:0] cell_height_q;
	logic [COLS_W-1:0]    grid_columns_q;
	logic [1:0]           pend_q;
	logic [CP_W-1:0]      part_q;
	logic [GLYPH_W-1:0]   glyphs_q;
	logic [TABLE_AW-1:0]  cell_q;
	logic                 out_valid_q;
	ugal_out_t            out_q;

	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	logic [7:0]           c;
	logic [CP_W-1:0]      p_ext;
	logic [1:0]           pend_d;
	logic [CP_W-1:0]      part_d;
	logic                 emit_en;
	logic [CP_W-1:0]      emit_cp;
	logic [1:0]           act;
	logic [COUNT_W-1:0]   n_search;
	logic [COLS_W-1:0]    cols;

	ugal_tbl_wr_t         tbl_wr;
	ugal_search_req_t     srch_req;
	ugal_search_rsp_t     srch_rsp;
	ugal_div_req_t        div_req;
	ugal_div_rsp_t        div_rsp;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_MUL || state_q == S_FIN) && out_free;

	// utf-8 decode of the incoming byte
	always_comb begin
		c       = in_data.text_byte;
		p_ext   = {part_q[CP_W-7:0], c[5:0]};
		pend_d  = pend_q;
		part_d  = part_q;
		emit_en = 1'b0;
		emit_cp = '0;
		act     = ACT_NONE;
		if (c == 8'h00) begin
			act    = ACT_FIN;
			pend_d = '0;
			part_d = '0;
		end else if (pend_q != 2'd0) begin
			part_d = p_ext;
			pend_d = pend_q - 2'd1;
			if (pend_q == 2'd1) begin
				emit_en = 1'b1;
				emit_cp = p_ext;
			end
		end else if (c[7] == 1'b0) begin
			emit_en = 1'b1;
			emit_cp = CP_W'(c);
		end else if (c[7:5] == 3'b110) begin
			part_d = CP_W'(c[4:0]);
			pend_d = 2'd1;
		end else if (c[7:4] == 4'b1110) begin
			part_d = CP_W'(c[3:0]);
			pend_d = 2'd2;
		end else if (c[7:3] == 5'b11110) begin
			part_d = CP_W'(c[2:0]);
			pend_d = 2'd3;
		end else begin
			// invalid lead passes through as its own value
			emit_en = 1'b1;
			emit_cp = CP_W'(c);
		end
		if (emit_en) begin
			if (emit_cp == '0) begin
				act    = ACT_FIN;
				pend_d = '0;
				part_d = '0;
			end else if (glyphs_q < GLYPH_W'(GLYPH_LIMIT) && emit_cp[CP_W-1:16] == '0) begin
				act = ACT_SEARCH;
			end
		end
	end

	always_comb begin
		n_search = (entry_count_q > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
			: entry_count_q;
		cols = (grid_columns_q == '0) ? COLS_W'(1) : grid_columns_q;

		tbl_wr.en        = accept && in_data.req_type == REQ_TABLE_WRITE;
		tbl_wr.index     = in_data.entry_index[TABLE_AW-1:0];
		tbl_wr.codepoint = in_data.entry_codepoint;

		srch_req.start     = accept && in_data.req_type == REQ_TEXT_BYTE && act == ACT_SEARCH;
		srch_req.codepoint = emit_cp[15:0];
		srch_req.count     = n_search;

		div_req.start    = state_q == S_SEARCH && srch_rsp.done && srch_rsp.hit;
		div_req.dividend = 8'(srch_rsp.index);
		div_req.divisor  = cols;
	end

	ugal_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.req    (srch_req),
		.rsp    (srch_rsp)
	);

	ugal_divmod u_divmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q  <= '0;
			cell_width_q   <= CWIDTH_W'(16);
			cell_height_q  <= CHEIGHT_W'(16);
			grid_columns_q <= COLS_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_COUNT:  entry_count_q  <= cfg_data[COUNT_W-1:0];
				REG_CELL_WIDTH:   cell_width_q   <= cfg_data[CWIDTH_W-1:0];
				REG_CELL_HEIGHT:  cell_height_q  <= cfg_data[CHEIGHT_W-1:0];
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data[COLS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= '0;
			part_q      <= '0;
			glyphs_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && in_data.req_type == REQ_TEXT_BYTE) begin
						pend_q <= pend_d;
						part_q <= part_d;
						if (act == ACT_FIN) begin
							state_q <= S_FIN;
						end else if (act == ACT_SEARCH) begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (srch_rsp.done) begin
						state_q <= srch_rsp.hit ? S_DIV : S_IDLE;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (out_free) begin
						glyphs_q    <= glyphs_q + GLYPH_W'(1);
						state_q     <= S_IDLE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						glyphs_q    <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEARCH && srch_rsp.done) begin
			cell_q <= srch_rsp.index;
		end
		if (state_q == S_MUL && out_free) begin
			out_q.result_kind <= KIND_GLYPH;
			out_q.cell_index  <= 8'(cell_q);
			out_q.source_x    <= 14'(div_rsp.remainder * cell_width_q);
			out_q.source_y    <= 14'(div_rsp.quotient * cell_height_q);
			out_q.pen_x       <= 11'(glyphs_q * cell_width_q);
			out_q.glyph_total <= '0;
			out_q.text_width  <= '0;
		end else if (state_q == S_FIN && out_free) begin
			out_q.result_kind <= KIND_END;
			out_q.cell_index  <= '0;
			out_q.source_x    <= '0;
			out_q.source_y    <= '0;
			out_q.pen_x       <= '0;
			out_q.glyph_total <= glyphs_q;
			out_q.text_width  <= 11'(glyphs_q * cell_width_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_glyph_cap: assert property (@(posedge clk) disable iff (!arst_n)
		glyphs_q <= GLYPH_W'(GLYPH_LIMIT))
		else $error("glyph count above limit");
	a_rsp_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_rsp.done |-> state_q == S_SEARCH)
		else $error("search result outside search state");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider result outside divide state");
	a_glyph_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL && out_free |=> out_valid_q && out_q.result_kind == KIND_GLYPH)
		else $error("glyph beat not loaded");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the UTF-8 glyph atlas lookup core
// A fixed opening script covers the field extremes, every sequence length,
// bad lead bytes, the zero-ending cases and a table write in mid-string.
// Random strings of table hits, misses and noise follow, over several
// register layouts. Every accepted beat runs through a local decoder and
// table search. Results are compared field by field, in order, while both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import ugal_pkg::*;

	localparam int OPENING_ROWS   = 25;
	localparam int RESET_ROWS     = 2;
	localparam int SETTLE_CYCLES  = 24;
	localparam int HOLD_CYCLES    = 400;
	localparam int QUIET_LIMIT    = 4000;
	localparam int PHASE_BEATS    = 125;
	localparam ugal_out_t NO_RESULT = '0;

	typedef struct packed {
		ugal_in_t  beat;
		logic      given;
		ugal_out_t want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	ugal_in_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	ugal_out_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// local copy of the block state and registers
	logic [15:0] cp_table [TABLE_DEPTH];
	logic [1:0]  seq_left = '0;
	logic [20:0] seq_cp = '0;
	int          glyph_count = 0;
	logic [8:0]  cfg_count = 9'd0;
	logic [6:0]  cfg_cell_w = 7'd16;
	logic [6:0]  cfg_cell_h = 7'd16;
	logic [8:0]  cfg_cols = 9'd16;

	ugal_out_t   atlas_results_q [$];
	script_row_t opening [OPENING_ROWS];

	int fails = 0;
	int beats_in = 0;
	int table_writes = 0;
	int glyphs_checked = 0;
	int ends_checked = 0;
	int layouts_used = 0;
	int send_rush = 0;
	int hold_requests = 0;

	utf8_glyph_atlas_lookup_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// binary search with the midpoint rounded down, first matching probe wins
	function automatic int probe_table(input logic [20:0] cp);
		int lo, hi, mid, n;
		n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
		lo = 0;
		hi = n - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (cp_table[mid] == cp)
				return mid;
			if (cp_table[mid] < cp)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return -1;
	endfunction

	function automatic bit close_string(output ugal_out_t r);
		int w;
		w = glyph_count * cfg_cell_w;
		r = NO_RESULT;
		r.result_kind = KIND_END;
		r.glyph_total = glyph_count[4:0];
		r.text_width = w[10:0];
		seq_left = '0;
		seq_cp = '0;
		glyph_count = 0;
		return 1'b1;
	endfunction

	function automatic bit place_glyph(input logic [20:0] cp, output ugal_out_t r);
		int g, cols, sx, sy, pen;
		r = NO_RESULT;
		if (cp == 0)
			return close_string(r);
		if (glyph_count >= GLYPH_LIMIT)
			return 1'b0;
		g = probe_table(cp);
		if (g < 0)
			return 1'b0;
		cols = (cfg_cols == 0) ? 1 : int'(cfg_cols);
		sx = (g % cols) * cfg_cell_w;
		sy = (g / cols) * cfg_cell_h;
		pen = glyph_count * cfg_cell_w;
		r.result_kind = KIND_GLYPH;
		r.cell_index = g[7:0];
		r.source_x = sx[13:0];
		r.source_y = sy[13:0];
		r.pen_x = pen[10:0];
		glyph_count++;
		return 1'b1;
	endfunction

	function automatic bit decode_beat(input ugal_in_t b, output ugal_out_t r);
		logic [7:0] c;
		r = NO_RESULT;
		if (b.req_type == REQ_TABLE_WRITE) begin
			cp_table[b.entry_index] = b.entry_codepoint;
			return 1'b0;
		end
		c = b.text_byte;
		if (c == 8'h00)
			return close_string(r);
		if (seq_left != 0) begin
			// continuation bits are taken without checking the 10xxxxxx pattern
			seq_cp = {seq_cp[14:0], c[5:0]};
			seq_left = seq_left - 2'd1;
			if (seq_left != 0)
				return 1'b0;
			return place_glyph(seq_cp, r);
		end
		if (c[7] == 1'b0)
			return place_glyph({13'd0, c}, r);
		if (c[7:5] == 3'b110) begin
			seq_cp = {16'd0, c[4:0]};
			seq_left = 2'd1;
			return 1'b0;
		end
		if (c[7:4] == 4'b1110) begin
			seq_cp = {17'd0, c[3:0]};
			seq_left = 2'd2;
			return 1'b0;
		end
		if (c[7:3] == 5'b11110) begin
			seq_cp = {18'd0, c[2:0]};
			seq_left = 2'd3;
			return 1'b0;
		end
		// bad lead byte stands for itself
		return place_glyph({13'd0, c}, r);
	endfunction

	function automatic int draw_wait(inout int rush);
		if (rush > 0) begin
			rush--;
			return 0;
		end
		if ($urandom_range(7, 0) == 0) begin
			rush = $urandom_range(40, 10);
			return 0;
		end
		return $urandom_range(16, 0);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_beat(input ugal_in_t b, input logic given, input ugal_out_t want);
		int gap;
		bit has_result;
		ugal_out_t r;
		gap = draw_wait(send_rush);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		has_result = decode_beat(b, r);
		if (given)
			atlas_results_q.push_back(want);
		else if (has_result)
			atlas_results_q.push_back(r);
		beats_in++;
		if (b.req_type == REQ_TABLE_WRITE)
			table_writes++;
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] c);
		ugal_in_t b;
		b.req_type = REQ_TEXT_BYTE;
		b.text_byte = c;
		b.entry_index = 8'($urandom_range(255, 0));
		b.entry_codepoint = 16'($urandom_range(16'hFFFF, 0));
		send_beat(b, 1'b0, NO_RESULT);
	endtask

	task automatic send_write(input logic [7:0] idx, input logic [15:0] cp);
		ugal_in_t b;
		b.req_type = REQ_TABLE_WRITE;
		b.text_byte = 8'($urandom_range(255, 0));
		b.entry_index = idx;
		b.entry_codepoint = cp;
		send_beat(b, 1'b0, NO_RESULT);
	endtask

	task automatic put_char(input logic [20:0] cp);
		int len;
		len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
		// overlong form now and then
		if (len < 4 && $urandom_range(9, 0) == 0)
			len++;
		case (len)
			1: send_text(cp[7:0]);
			2: begin
				send_text({3'b110, cp[10:6]});
				send_text({2'b10, cp[5:0]});
			end
			3: begin
				send_text({4'b1110, cp[15:12]});
				send_text({2'b10, cp[11:6]});
				send_text({2'b10, cp[5:0]});
			end
			default: begin
				send_text({5'b11110, cp[20:18]});
				send_text({2'b10, cp[17:12]});
				send_text({2'b10, cp[11:6]});
				send_text({2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ENTRY_COUNT:  cfg_count = val;
			REG_CELL_WIDTH:   cfg_cell_w = val[6:0];
			REG_CELL_HEIGHT:  cfg_cell_h = val[6:0];
			REG_GRID_COLUMNS: cfg_cols = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_layout(input logic [8:0] count, input logic [8:0] cw,
			input logic [8:0] ch, input logic [8:0] cols);
		write_reg(REG_ENTRY_COUNT, count);
		write_reg(REG_CELL_WIDTH, cw);
		write_reg(REG_CELL_HEIGHT, ch);
		write_reg(REG_GRID_COLUMNS, cols);
		cfg_we <= 1'b0;
		layouts_used++;
	endtask

	// drain every expected result, then give a lookup that makes no result time to finish
	task automatic settle();
		in_valid <= 1'b0;
		while (atlas_results_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_opening(input int first, input int last);
		for (int i = first; i <= last; i++)
			send_beat(opening[i].beat, opening[i].given, opening[i].want);
	endtask

	task automatic run_random_phase(input int quota);
		int start, nchars, r, n, idx;
		bit long_str;
		logic [20:0] cp;
		logic [15:0] lo, hi, val;
		start = beats_in;
		while (beats_in - start < quota) begin
			if ($urandom_range(11, 0) == 0) begin
				// mostly keep the table in order, sometimes break it
				idx = $urandom_range(255, 0);
				lo = (idx > 0) ? cp_table[idx - 1] : 16'h0000;
				hi = (idx < 255) ? cp_table[idx + 1] : 16'hFFFF;
				if ($urandom_range(3, 0) != 0 && lo <= hi)
					val = 16'($urandom_range(hi, lo));
				else
					val = 16'($urandom_range(16'hFFFF, 0));
				send_write(idx[7:0], val);
			end else begin
				long_str = ($urandom_range(5, 0) == 0);
				nchars = long_str ? $urandom_range(34, 26) : $urandom_range(12, 0);
				for (int k = 0; k < nchars; k++) begin
					r = long_str ? 0 : $urandom_range(99, 0);
					if (r < 70) begin
						n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
						idx = (n > 0) ? $urandom_range(n - 1, 0) : $urandom_range(255, 0);
						put_char({5'd0, cp_table[idx]});
					end else if (r < 85) begin
						cp = 21'($urandom_range(21'h1FFFFF, 0));
						put_char(cp);
					end else begin
						send_text(8'($urandom_range(255, 1)));
					end
				end
				r = $urandom_range(19, 0);
				if (r == 0) begin
					// cut-off sequence ended by a zero byte
					if ($urandom_range(1, 0) == 0)
						send_text({4'b1110, 4'($urandom_range(15, 0))});
					else
						send_text({5'b11110, 3'($urandom_range(7, 0))});
					if ($urandom_range(1, 0) == 0)
						send_text({2'b10, 6'($urandom_range(63, 0))});
				end
				// otherwise a string now and then runs on into the next one
				if (r != 1)
					send_text(8'h00);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// output side: checks results and draws stalls
	initial begin : drain
		int wait_left, hold_left, rush, holds_served;
		ugal_out_t want;
		wait_left = 0;
		hold_left = 0;
		rush = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (atlas_results_q.size() == 0) begin
					$error("result with nothing expected: kind %0d cell %0d",
						out_data.result_kind, out_data.cell_index);
					fails++;
				end else begin
					want = atlas_results_q.pop_front();
					check_field("result_kind", 16'(want.result_kind), 16'(out_data.result_kind));
					check_field("cell_index", 16'(want.cell_index), 16'(out_data.cell_index));
					check_field("source_x", 16'(want.source_x), 16'(out_data.source_x));
					check_field("source_y", 16'(want.source_y), 16'(out_data.source_y));
					check_field("pen_x", 16'(want.pen_x), 16'(out_data.pen_x));
					check_field("glyph_total", 16'(want.glyph_total), 16'(out_data.glyph_total));
					check_field("text_width", 16'(want.text_width), 16'(out_data.text_width));
				end
				if (out_data.result_kind == KIND_END)
					ends_checked++;
				else
					glyphs_checked++;
				wait_left = draw_wait(rush);
			end
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (wait_left > 0) begin
				out_stall <= 1'b1;
				wait_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : stimulus
		logic [8:0] layouts [5][4];
		logic [15:0] cp;
		// count, cell width, cell height, columns
		layouts = '{
			'{9'd300, 9'd1, 9'd1, 9'd1},
			'{9'h1FF, 9'h1FF, 9'd127, 9'd0},
			'{9'd256, 9'd64, 9'd64, 9'd256},
			'{9'd37, 9'd7, 9'd13, 9'd255},
			'{9'd1, 9'd0, 9'd0, 9'h1FF}
		};
		// rows 0-1 run on reset registers, the rest on 256 entries, 64x64 cells, 16 columns
		opening = '{
			'{'{REQ_TEXT_BYTE, 8'h41, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h00, 8'h00, 16'h0000}, 1'b1,
				'{KIND_END, 8'd0, 14'd0, 14'd0, 11'd0, 5'd0, 11'd0}},
			'{'{REQ_TEXT_BYTE, 8'h41, 8'h00, 16'h0000}, 1'b1,
				'{KIND_GLYPH, 8'd65, 14'd64, 14'd256, 11'd0, 5'd0, 11'd0}},
			'{'{REQ_TEXT_BYTE, 8'h7F, 8'h00, 16'h0000}, 1'b1,
				'{KIND_GLYPH, 8'd127, 14'd960, 14'd448, 11'd64, 5'd0, 11'd0}},
			'{'{REQ_TEXT_BYTE, 8'hC2, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h80, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'hEF, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'hBF, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'hBF, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'hF0, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h90, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h80, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h80, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h80, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'hFF, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h00, 8'h00, 16'h0000}, 1'b1,
				'{KIND_END, 8'd0, 14'd0, 14'd0, 11'd0, 5'd5, 11'd320}},
			'{'{REQ_TEXT_BYTE, 8'hE2, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h82, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h00, 8'h00, 16'h0000}, 1'b1,
				'{KIND_END, 8'd0, 14'd0, 14'd0, 11'd0, 5'd0, 11'd0}},
			'{'{REQ_TEXT_BYTE, 8'hC0, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h80, 8'h00, 16'h0000}, 1'b1,
				'{KIND_END, 8'd0, 14'd0, 14'd0, 11'd0, 5'd0, 11'd0}},
			'{'{REQ_TEXT_BYTE, 8'hC2, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TABLE_WRITE, 8'h00, 8'd200, 16'h2740}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'hDE, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
			'{'{REQ_TEXT_BYTE, 8'h00, 8'h00, 16'h0000}, 1'b1,
				'{KIND_END, 8'd0, 14'd0, 14'd0, 11'd0, 5'd1, 11'd64}}
		};

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: empty table range, nothing can match
		run_opening(0, RESET_ROWS - 1);

		// ascii, then 2-byte, then 3-byte ranges, last entry at the top
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i < 128)
				cp = 16'(i);
			else if (i < 192)
				cp = 16'(16'h80 + (i - 128) * 30);
			else if (i < 255)
				cp = 16'(16'h800 + (i - 192) * 1000);
			else
				cp = 16'hFFFF;
			send_write(8'(i), cp);
		end

		settle();
		set_layout(9'd256, 9'd64, 9'd64, 9'd16);
		run_opening(RESET_ROWS, OPENING_ROWS - 1);

		for (int p = 0; p < 5; p++) begin
			settle();
			set_layout(layouts[p][0], layouts[p][1], layouts[p][2], layouts[p][3]);
			// long output hold while input keeps coming, to back the core up
			if (p == 2)
				hold_requests++;
			run_random_phase(PHASE_BEATS);
		end

		settle();
		$display("run: %0d beats in (%0d table writes) over %0d register layouts",
			beats_in, table_writes, layouts_used);
		$display("run: %0d glyph results and %0d string ends checked, %0d failures",
			glyphs_checked, ends_checked, fails);
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
